FILE: rtl/grbf_pkg.sv
// Package for the Gaussian radial-basis displacement evaluator.
// Holds the payload types, the field widths and the exponential tables.
// No dependencies.
package grbf_pkg;

    localparam int POS_W   = 24;
    localparam int RAD_W   = 16;
    localparam int DISP_W  = 32;
    localparam int CNT_W   = 7;
    localparam int SLOT_W  = 6;
    localparam int DIFF_W  = POS_W + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int D2_W    = SQ_W + 2;
    localparam int R2_W    = 2 * RAD_W;
    localparam int T_W     = 20;
    localparam int W_W     = 17;
    localparam int TERM_W  = POS_W + W_W + 1;
    localparam int ACC_W   = TERM_W + 11;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_POINT = 1'b1;

    typedef struct packed {
        logic                     func;
        logic [SLOT_W-1:0]        landmark_slot;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic [RAD_W-1:0]         radius;
        logic signed [POS_W-1:0]  coeff_x;
        logic signed [POS_W-1:0]  coeff_y;
        logic signed [POS_W-1:0]  coeff_z;
    } grbf_in_t;

    typedef struct packed {
        logic signed [DISP_W-1:0] disp_x;
        logic signed [DISP_W-1:0] disp_y;
        logic signed [DISP_W-1:0] disp_z;
    } grbf_out_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } grbf_vec_t;

    typedef struct packed {
        logic                    valid;
        logic [D2_W-1:0]         d2;
        logic [R2_W-1:0]         r2;
        logic                    zero_w;
        grbf_vec_t               coeff;
    } grbf_sq_t;

    function automatic logic [16:0] exp_int(input logic [3:0] n);
        logic [16:0] v;
        unique case (n)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_frac(input logic [3:0] k);
        logic [16:0] v;
        unique case (k)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd61565;
            4'd2:  v = 17'd57835;
            4'd3:  v = 17'd54331;
            4'd4:  v = 17'd51039;
            4'd5:  v = 17'd47947;
            4'd6:  v = 17'd45042;
            4'd7:  v = 17'd42313;
            4'd8:  v = 17'd39750;
            4'd9:  v = 17'd37341;
            4'd10: v = 17'd35079;
            4'd11: v = 17'd32953;
            4'd12: v = 17'd30957;
            4'd13: v = 17'd29081;
            4'd14: v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/grbf_div_cell.sv
// One restoring division step of the ratio chain: one quotient bit per cell.
// Depends on grbf_pkg.
module grbf_div_cell
    import grbf_pkg::*;
#(
    parameter int QBIT = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [D2_W+16:0]  in_rem,
    input  logic [R2_W-1:0]   in_r2,
    input  logic [T_W-1:0]    in_q,
    input  logic              in_zero,
    input  grbf_vec_t         in_coeff,
    output logic              out_valid,
    output logic [D2_W+16:0]  out_rem,
    output logic [R2_W-1:0]   out_r2,
    output logic [T_W-1:0]    out_q,
    output logic              out_zero,
    output grbf_vec_t         out_coeff
);

    logic [D2_W+16:0] shifted;
    logic             fits;
    logic             valid_reg;
    logic [D2_W+16:0] rem_reg;
    logic [R2_W-1:0]  r2_reg;
    logic [T_W-1:0]   q_reg;
    logic             zero_reg;
    grbf_vec_t        coeff_reg;

    assign shifted = {{(D2_W+17-R2_W){1'b0}}, in_r2} << QBIT;
    assign fits    = in_rem >= shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
        rem_reg   <= fits ? in_rem - shifted : in_rem;
        r2_reg    <= in_r2;
        q_reg     <= in_q | (T_W'(fits) << QBIT);
        zero_reg  <= in_zero;
        coeff_reg <= in_coeff;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_r2    = r2_reg;
    assign out_q     = q_reg;
    assign out_zero  = zero_reg;
    assign out_coeff = coeff_reg;

endmodule

FILE: rtl/grbf_weight_acc.sv
// Gaussian weight from the ratio, coefficient product and saturating sum.
// Depends on grbf_pkg.
module grbf_weight_acc
    import grbf_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            clear,
    input  logic            in_valid,
    input  logic [T_W-1:0]  in_t,
    input  logic            in_zero,
    input  grbf_vec_t       in_coeff,
    output logic            idle,
    output grbf_out_t       sum
);

    logic [3:0]             n;
    logic [3:0]             k;
    logic [11:0]            g;
    logic [33:0]            ef_prod;
    logic                   s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [16:0]            a_reg;
    logic [16:0]            p_reg;
    logic                   s1_zero_reg;
    grbf_vec_t              s1_coeff_reg, s2_coeff_reg;
    logic [16:0]            w_reg;
    logic [33:0]            ap;
    logic signed [TERM_W-1:0] tx_reg, ty_reg, tz_reg;
    logic signed [ACC_W-1:0]  ax_reg, ay_reg, az_reg;

    assign n = in_t[19:16];
    assign k = in_t[15:12];
    assign g = in_t[11:0];
    assign ef_prod = exp_int(n) * exp_frac(k) + 34'd32768;
    assign ap = a_reg * p_reg + 34'd32768;

    function automatic logic signed [DISP_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-9:0] q;
        q = (ACC_W-8)'(acc >>> 8);
        if (q > $signed((ACC_W-8)'(32'h7fffffff)))
            return 32'h7fffffff;
        else if (q < -$signed((ACC_W-8)'(33'h80000000)))
            return 32'h80000000;
        return DISP_W'(q);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
        a_reg        <= ef_prod[32:16];
        p_reg        <= 17'd65536 - 17'(g) + 17'((24'(g) * 24'(g)) >> 17);
        s1_zero_reg  <= in_zero || (n >= 4'd12);
        s1_coeff_reg <= in_coeff;
        w_reg        <= s1_zero_reg ? 17'd0 : ap[32:16];
        s2_coeff_reg <= s1_coeff_reg;
        tx_reg <= s2_coeff_reg.x * $signed({1'b0, w_reg});
        ty_reg <= s2_coeff_reg.y * $signed({1'b0, w_reg});
        tz_reg <= s2_coeff_reg.z * $signed({1'b0, w_reg});
        if (clear) begin
            ax_reg <= '0;
            ay_reg <= '0;
            az_reg <= '0;
        end else if (s3_valid_reg) begin
            ax_reg <= ax_reg + ACC_W'(tx_reg);
            ay_reg <= ay_reg + ACC_W'(ty_reg);
            az_reg <= az_reg + ACC_W'(tz_reg);
        end
    end

    assign idle = !(in_valid || s1_valid_reg || s2_valid_reg || s3_valid_reg);
    assign sum.disp_x = finish(ax_reg);
    assign sum.disp_y = finish(ay_reg);
    assign sum.disp_z = finish(az_reg);

endmodule

FILE: rtl/gaussian_rbf_displacement_eval_core.sv
// Top level of the Gaussian radial-basis displacement evaluator.
// Depends on grbf_pkg, grbf_div_cell and grbf_weight_acc.
//
// Input words arrive on s_valid/s_ready/s_data. A load word (func 0) writes one
// landmark slot and gives no result. A point word (func 1) streams slots
// 0 .. active_landmarks-1 out of the landmark memory, one slot a cycle, into a
// squared-distance stage, a chain of 20 division cells that produce the ratio
// d2/r2 one quotient bit per cell, and the weight and sum stages. With count
// the capped landmark count, m_valid rises once all count slots have passed
// these stages (an empty table gives a zero vector), and s_ready is low for the
// whole walk; the landmark memory has a single read port, read once per slot.
// The result word is held on m_data with m_valid until m_ready; the next input
// word is taken as soon as the result is registered, even while it waits.
// active_landmarks is written on cfg_valid/cfg_ready/cfg_data; values above
// MAX_LANDMARKS count as MAX_LANDMARKS. Reset clears the count and the control
// state; the landmark memory stays unwritten, so slots must be loaded before use.
// A receiver stall holds the result word and, once a second point word is
// finished, holds s_ready low.
module gaussian_rbf_displacement_eval_core
    import grbf_pkg::*;
#(
    parameter int MAX_LANDMARKS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  grbf_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output grbf_out_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CNT_W-1:0]     cfg_data
);

    localparam int IDX_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int CNT_IW = $clog2(MAX_LANDMARKS + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_IW-1:0]   limit;
    logic [CNT_IW-1:0]   idx_reg;
    grbf_vec_t           query_reg;
    grbf_vec_t           pos_mem [MAX_LANDMARKS];
    grbf_vec_t           coeff_mem [MAX_LANDMARKS];
    logic [RAD_W-1:0]    rad_mem [MAX_LANDMARKS];
    grbf_vec_t           rd_pos_reg, rd_coeff_reg;
    logic [RAD_W-1:0]    rd_rad_reg;
    logic                rd_valid_reg;
    grbf_sq_t            sq_reg;
    logic                out_valid_reg;
    grbf_out_t           out_data_reg;
    logic                s_fire;
    logic                acc_idle;
    logic                chain_busy;
    grbf_out_t           acc_sum;
    logic                clear;

    logic signed [DIFF_W-1:0] dx, dy, dz;
    logic [D2_W-1:0]          d2;
    logic [R2_W-1:0]          r2;

    logic              cv [T_W+1];
    logic [D2_W+16:0]  crem [T_W+1];
    logic [R2_W-1:0]   cr2 [T_W+1];
    logic [T_W-1:0]    cq [T_W+1];
    logic              czero [T_W+1];
    grbf_vec_t         ccoeff [T_W+1];

    assign limit = (32'(count_reg) > MAX_LANDMARKS) ? CNT_IW'(MAX_LANDMARKS)
                                                    : CNT_IW'(count_reg);
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign clear     = s_fire && s_data.func == FUNC_POINT;

    always_comb begin
        chain_busy = 1'b0;
        for (int i = 1; i <= T_W; i++)
            chain_busy = chain_busy | cv[i];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (clear) state_next = ST_WALK;
            ST_WALK:  if (idx_reg >= limit) state_next = ST_DRAIN;
            ST_DRAIN: if (acc_idle && !chain_busy && !rd_valid_reg && !sq_reg.valid
                          && !out_valid_reg)
                          state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) count_reg <= cfg_data;
            if (clear) idx_reg <= '0;
            else if (state_reg == ST_WALK && idx_reg < limit) idx_reg <= idx_reg + 1'b1;
            rd_valid_reg <= (state_reg == ST_WALK) && (idx_reg < limit);
            if (state_reg == ST_DRAIN && state_next == ST_IDLE && !out_valid_reg)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (clear) query_reg <= '{s_data.pos_x, s_data.pos_y, s_data.pos_z};
        if (s_fire && s_data.func == FUNC_LOAD
            && 32'(s_data.landmark_slot) < MAX_LANDMARKS) begin
            pos_mem[IDX_W'(s_data.landmark_slot)]   <= '{s_data.pos_x, s_data.pos_y,
                                                         s_data.pos_z};
            coeff_mem[IDX_W'(s_data.landmark_slot)] <= '{s_data.coeff_x, s_data.coeff_y,
                                                         s_data.coeff_z};
            rad_mem[IDX_W'(s_data.landmark_slot)]   <= s_data.radius;
        end
        rd_pos_reg   <= pos_mem[IDX_W'(idx_reg)];
        rd_coeff_reg <= coeff_mem[IDX_W'(idx_reg)];
        rd_rad_reg   <= rad_mem[IDX_W'(idx_reg)];
        if (state_reg == ST_DRAIN && state_next == ST_IDLE && !out_valid_reg)
            out_data_reg <= acc_sum;
    end

    assign dx = DIFF_W'(query_reg.x) - DIFF_W'(rd_pos_reg.x);
    assign dy = DIFF_W'(query_reg.y) - DIFF_W'(rd_pos_reg.y);
    assign dz = DIFF_W'(query_reg.z) - DIFF_W'(rd_pos_reg.z);
    assign r2 = rd_rad_reg * rd_rad_reg;
    assign d2 = D2_W'(SQ_W'(dx * dx)) + D2_W'(SQ_W'(dy * dy)) + D2_W'(SQ_W'(dz * dz));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg.valid <= 1'b0;
        end else begin
            sq_reg.valid <= rd_valid_reg;
        end
        sq_reg.d2     <= d2;
        sq_reg.r2     <= r2;
        sq_reg.zero_w <= (rd_rad_reg == '0) || (D2_W'(d2) >= D2_W'(r2) * D2_W'(12));
        sq_reg.coeff  <= rd_coeff_reg;
    end

    assign cv[0]     = sq_reg.valid;
    assign crem[0]   = {sq_reg.d2, 16'd0};
    assign cr2[0]    = sq_reg.r2;
    assign cq[0]     = '0;
    assign czero[0]  = sq_reg.zero_w;
    assign ccoeff[0] = sq_reg.coeff;

    for (genvar i = 0; i < T_W; i++) begin : g_div
        grbf_div_cell #(.QBIT(T_W - 1 - i)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cv[i]),
            .in_rem    (crem[i]),
            .in_r2     (cr2[i]),
            .in_q      (cq[i]),
            .in_zero   (czero[i]),
            .in_coeff  (ccoeff[i]),
            .out_valid (cv[i+1]),
            .out_rem   (crem[i+1]),
            .out_r2    (cr2[i+1]),
            .out_q     (cq[i+1]),
            .out_zero  (czero[i+1]),
            .out_coeff (ccoeff[i+1])
        );
    end

    grbf_weight_acc u_acc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (clear),
        .in_valid (cv[T_W]),
        .in_t     (cq[T_W]),
        .in_zero  (czero[T_W]),
        .in_coeff (ccoeff[T_W]),
        .idle     (acc_idle),
        .sum      (acc_sum)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: rtl/grbf_checker.sv
// Port-level checks for the displacement evaluator, bound to the top level.
// Depends on grbf_pkg and gaussian_rbf_displacement_eval_core.
module grbf_checker
    import grbf_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input grbf_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input grbf_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_point_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.func == FUNC_POINT |=> !s_ready)
        else $error("input taken during point walk");

    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.func == FUNC_POINT && !m_valid |=> !m_valid)
        else $error("result word before walk");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word after reset");

endmodule

bind gaussian_rbf_displacement_eval_core grbf_checker u_grbf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: bench/gaussian_rbf_displacement_eval_core_test.sv
// Self-checking bench for gaussian_rbf_displacement_eval_core: loads landmark
// tables, evaluates points under several landmark counts and idling mixes.
// Depends on grbf_pkg and the core RTL.
`timescale 1ns / 100ps

module gaussian_rbf_displacement_eval_core_test;
    import grbf_pkg::*;

    localparam int NSLOTS     = 64;
    localparam int SETTLE     = 120;
    localparam int STALL_LIMIT = 20000;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    grbf_in_t          s_data;
    logic              m_valid;
    logic              m_ready;
    grbf_out_t         m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data;

    gaussian_rbf_displacement_eval_core #(.MAX_LANDMARKS(NSLOTS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    logic signed [POS_W-1:0] lm_px [NSLOTS];
    logic signed [POS_W-1:0] lm_py [NSLOTS];
    logic signed [POS_W-1:0] lm_pz [NSLOTS];
    logic [RAD_W-1:0]        lm_rad [NSLOTS];
    logic signed [POS_W-1:0] lm_cx [NSLOTS];
    logic signed [POS_W-1:0] lm_cy [NSLOTS];
    logic signed [POS_W-1:0] lm_cz [NSLOTS];
    int unsigned             n_active;

    grbf_in_t   pending_words[$];
    grbf_out_t  expected_disp[$];
    int         mismatches;
    int         quiet_cycles;
    int         s_idle_pct, m_idle_pct;
    logic       s_took, cfg_took;
    logic signed [POS_W-1:0] cx0, cy0, cz0;

    longint unsigned exp_int_lut [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                          22, 8, 3, 1};
    longint unsigned exp_frac_lut [16] = '{65536, 61565, 57835, 54331, 51039, 47947,
                                           45042, 42313, 39750, 37341, 35079, 32953,
                                           30957, 29081, 27319, 25664};

    function automatic longint unsigned gauss_weight(longint unsigned d2,
                                                     longint unsigned rad);
        longint unsigned r2, t, a, p, g, n, k;
        if (rad == 0) return 0;
        r2 = rad * rad;
        if (d2 >= 12 * r2) return 0;
        t = (d2 << 16) / r2;
        n = t >> 16;
        k = (t >> 12) & 15;
        g = t & 4095;
        a = (exp_int_lut[n] * exp_frac_lut[k] + 32768) >> 16;
        p = 65536 - g + ((g * g) >> 17);
        return (a * p + 32768) >> 16;
    endfunction

    function automatic logic signed [DISP_W-1:0] to_q15_16(longint acc);
        longint q;
        q = acc >>> 8;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[DISP_W-1:0];
    endfunction

    function automatic grbf_out_t displacement_at(grbf_in_t w);
        longint ax, ay, az, dx, dy, dz, wt;
        int unsigned cnt;
        grbf_out_t r;
        ax = 0; ay = 0; az = 0;
        cnt = (n_active > NSLOTS) ? NSLOTS : n_active;
        for (int i = 0; i < cnt; i++) begin
            dx = longint'(w.pos_x) - longint'(lm_px[i]);
            dy = longint'(w.pos_y) - longint'(lm_py[i]);
            dz = longint'(w.pos_z) - longint'(lm_pz[i]);
            wt = longint'(gauss_weight(dx * dx + dy * dy + dz * dz, lm_rad[i]));
            ax += longint'(lm_cx[i]) * wt;
            ay += longint'(lm_cy[i]) * wt;
            az += longint'(lm_cz[i]) * wt;
        end
        r.disp_x = to_q15_16(ax);
        r.disp_y = to_q15_16(ay);
        r.disp_z = to_q15_16(az);
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] near(logic signed [POS_W-1:0] base,
                                                     int span);
        longint v;
        v = longint'(base) + longint'($urandom_range(0, 2 * span)) - span;
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[POS_W-1:0];
    endfunction

    function automatic grbf_in_t make_word(logic fn, int slot, longint x, longint y,
                                           longint z, int rad, longint cx, longint cy,
                                           longint cz);
        grbf_in_t w;
        w.func = fn;
        w.landmark_slot = slot[SLOT_W-1:0];
        w.pos_x = x[POS_W-1:0];
        w.pos_y = y[POS_W-1:0];
        w.pos_z = z[POS_W-1:0];
        w.radius = rad[RAD_W-1:0];
        w.coeff_x = cx[POS_W-1:0];
        w.coeff_y = cy[POS_W-1:0];
        w.coeff_z = cz[POS_W-1:0];
        return w;
    endfunction

    function automatic grbf_in_t random_load();
        grbf_in_t w;
        w = grbf_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        w.func = FUNC_LOAD;
        if ($urandom_range(0, 9) < 8) begin
            w.pos_x = near(cx0, 4096);
            w.pos_y = near(cy0, 4096);
            w.pos_z = near(cz0, 4096);
            w.radius = RAD_W'($urandom_range(1, 65535));
        end
        if ($urandom_range(0, 19) == 0) w.radius = '0;
        return w;
    endfunction

    function automatic grbf_in_t random_point();
        grbf_in_t w;
        int j, span;
        w = grbf_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        w.func = FUNC_POINT;
        if ($urandom_range(0, 9) < 8) begin
            j = $urandom_range(0, NSLOTS - 1);
            span = 2 * lm_rad[j] + 16;
            w.pos_x = near(lm_px[j], span);
            w.pos_y = near(lm_py[j], span);
            w.pos_z = near(lm_pz[j], span);
        end
        return w;
    endfunction

    task automatic drain();
        while (pending_words.size() != 0 || s_valid || expected_disp.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_count(int v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v[CNT_W-1:0];
        do @(negedge aclk); while (!cfg_took);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // drive input words at the falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= m_idle_pct);
        if (!s_valid || s_took) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= s_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_words.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        s_took   <= s_valid && s_ready;
        cfg_took <= cfg_valid && cfg_ready;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL gaussian_rbf_displacement_eval_core");
                $finish;
            end
            if (m_valid && m_ready) begin
                if (expected_disp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %h", m_data);
                end else begin
                    grbf_out_t e;
                    e = expected_disp.pop_front();
                    if (e.disp_x !== m_data.disp_x || e.disp_y !== m_data.disp_y
                            || e.disp_z !== m_data.disp_z) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     e.disp_x, e.disp_y, e.disp_z,
                                     m_data.disp_x, m_data.disp_y, m_data.disp_z);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                n_active = 32'(cfg_data);
            if (s_valid && s_ready) begin
                if (s_data.func == FUNC_POINT) begin
                    expected_disp.push_back(displacement_at(s_data));
                end else begin
                    lm_px[s_data.landmark_slot]  = s_data.pos_x;
                    lm_py[s_data.landmark_slot]  = s_data.pos_y;
                    lm_pz[s_data.landmark_slot]  = s_data.pos_z;
                    lm_rad[s_data.landmark_slot] = s_data.radius;
                    lm_cx[s_data.landmark_slot]  = s_data.coeff_x;
                    lm_cy[s_data.landmark_slot]  = s_data.coeff_y;
                    lm_cz[s_data.landmark_slot]  = s_data.coeff_z;
                end
            end
        end
    end

    initial begin
        int counts [6];
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_took = 1'b0;
        cfg_took = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        n_active = 0;
        s_idle_pct = 38;
        m_idle_pct = 80;
        cx0 = POS_W'($urandom_range(0, 2000000) - 1000000);
        cy0 = POS_W'($urandom_range(0, 2000000) - 1000000);
        cz0 = POS_W'($urandom_range(0, 2000000) - 1000000);
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty table gives a zero vector
        pending_words.push_back(make_word(FUNC_POINT, 63, 8388607, -8388608, 0,
                                          65535, 0, 0, 0));
        pending_words.push_back(make_word(FUNC_LOAD, 0, cx0, cy0, cz0, 0,
                                          8388607, 8388607, 8388607));
        pending_words.push_back(make_word(FUNC_LOAD, 1, cx0, cy0, cz0, 65535,
                                          8388607, 8388607, 8388607));
        pending_words.push_back(make_word(FUNC_LOAD, 2, cx0, cy0, cz0, 1,
                                          -8388608, -8388608, -8388608));
        pending_words.push_back(make_word(FUNC_LOAD, 3, 8388607, 8388607, 8388607,
                                          65535, -8388608, 8388607, -1));
        pending_words.push_back(make_word(FUNC_LOAD, 4, -8388608, -8388608, -8388608,
                                          65535, 8388607, -8388608, 1));
        for (int i = 5; i < 13; i++)
            pending_words.push_back(make_word(FUNC_LOAD, i, cx0, cy0, cz0, 65535,
                                              8388607, 8388607, -8388608));
        for (int i = 13; i < NSLOTS; i++) begin
            grbf_in_t w;
            w = random_load();
            w.landmark_slot = SLOT_W'(i);
            pending_words.push_back(w);
        end
        drain();
        write_count(13);
        pending_words.push_back(make_word(FUNC_POINT, 0, cx0, cy0, cz0, 0, 0, 0, 0));
        pending_words.push_back(make_word(FUNC_POINT, 0, 8388607, 8388607, 8388607,
                                          0, 0, 0, 0));
        pending_words.push_back(make_word(FUNC_POINT, 0, -8388608, -8388608, -8388608,
                                          0, 0, 0, 0));
        pending_words.push_back(make_word(FUNC_POINT, 0, cx0 + 100, cy0 - 50, cz0,
                                          0, 0, 0, 0));
        drain();

        counts = '{64, 127, 1, 37, 0, $urandom_range(2, 63)};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                s_idle_pct = 80;
                m_idle_pct = 38;
            end else if (ph == 4) begin
                s_idle_pct = 0;
                m_idle_pct = 0;
            end
            write_count(counts[ph]);
            for (int i = 0; i < 300; i++) begin
                if (ph == 1 && i == 150) begin
                    while (pending_words.size() != 0 || s_valid
                           || expected_disp.size() != 0)
                        @(posedge aclk);
                end
                if ($urandom_range(0, 99) < 25)
                    pending_words.push_back(random_load());
                else
                    pending_words.push_back(random_point());
                while (pending_words.size() > 8) @(posedge aclk);
            end
            drain();
        end

        if (mismatches == 0)
            $display("PASS gaussian_rbf_displacement_eval_core");
        else
            $display("FAIL gaussian_rbf_displacement_eval_core");
        $finish;
    end

endmodule

FILE: gaussian_rbf_displacement_eval_core.f
rtl/grbf_pkg.sv
rtl/grbf_div_cell.sv
rtl/grbf_weight_acc.sv
rtl/gaussian_rbf_displacement_eval_core.sv
rtl/grbf_checker.sv
bench/gaussian_rbf_displacement_eval_core_test.sv
